/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertions sampled on the rising clock edge; MBSP_ASSERT is held off during reset, MBSP_ASSERT_ALWAYS is not.
`ifndef SYNTHESIS
`define MBSP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MBSP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MBSP_ASSERT(label, clk, rst_n, prop, msg)
`define MBSP_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

/* rtl/mbsp_pkg.sv */
package mbsp_pkg;

    localparam logic [7:0] RealtimeFirst = 8'hF8;
    localparam logic [7:0] SysexStart    = 8'hF0;
    localparam logic [7:0] SysexEnd      = 8'hF7;
    localparam logic [7:0] NoteOffHi     = 8'h80;
    localparam logic [7:0] ProgramHi     = 8'hC0;
    localparam logic [7:0] PressureHi    = 8'hD0;
    localparam logic [7:0] PitchBendHi   = 8'hE0;
    localparam logic [7:0] ChannelMask   = 8'h0F;

    typedef enum logic [2:0] {
        EK_ABSORBED  = 3'd0,
        EK_MESSAGE   = 3'd1,
        EK_REALTIME  = 3'd2,
        EK_ERROR     = 3'd3,
        EK_SYSEX_ON  = 3'd4,
        EK_SYSEX_OFF = 3'd5
    } t_event_kind;

    // Number of data bytes that complete a message under this status.
    function automatic logic [1:0] needed_data(input logic [7:0] st);
        logic [7:0] hi;
        hi = st & ~ChannelMask;
        if (hi == ProgramHi || hi == PressureHi) begin
            return 2'd1;
        end else if (hi >= NoteOffHi && hi <= PitchBendHi) begin
            return 2'd2;
        end
        return 2'd0;
    endfunction

endpackage

/* rtl/mbsp_in_if.sv */
interface mbsp_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [31:0] time_ms;

    modport source (output valid, output data_byte, output time_ms, input ready);
    modport sink (input valid, input data_byte, input time_ms, output ready);
endinterface

/* rtl/mbsp_out_if.sv */
interface mbsp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [7:0]  evt_status;
    logic [7:0]  evt_type;
    logic [4:0]  evt_channel;
    logic [6:0]  evt_data1;
    logic [6:0]  evt_data2;
    logic [31:0] last_event_time;
    logic [31:0] byte_total;
    logic [31:0] message_total;
    logic [31:0] realtime_total;
    logic [31:0] error_total;
    logic [7:0]  current_running_status;

    modport source (
        output valid, input ready,
        output event_kind, output evt_status, output evt_type, output evt_channel,
        output evt_data1, output evt_data2, output last_event_time,
        output byte_total, output message_total, output realtime_total,
        output error_total, output current_running_status
    );
    modport sink (
        input valid, output ready,
        input event_kind, input evt_status, input evt_type, input evt_channel,
        input evt_data1, input evt_data2, input last_event_time,
        input byte_total, input message_total, input realtime_total,
        input error_total, input current_running_status
    );
endinterface

/* rtl/midi_byte_stream_parser.sv */
// Channel   Direction  Contents
// i_in      in         data_byte, time_ms
// o_out     out        event kind, last event fields, four counters, running status
// i_cfg_*   in         enable (write only)
//
// Parser state and the result register load at the same edge.
// A new word is taken in every cycle in which the result register is empty or being read.
// A stalled result holds, and the next word waits until it is read.
// Synchronous active-low reset clears all state and sets enable.
`include "assert_macros.svh"

module midi_byte_stream_parser
    import mbsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    mbsp_in_if.sink     i_in,
    mbsp_out_if.source  o_out
);

    logic        r_enable;
    logic [7:0]  r_run_stat, n_run_stat;
    logic [7:0]  r_pend_stat, n_pend_stat;
    logic [6:0]  r_pb0, n_pb0, r_pb1, n_pb1;
    logic [1:0]  r_pend_fill, n_pend_fill;
    logic [1:0]  r_exp_fill, n_exp_fill;
    logic        r_sysex, n_sysex;
    logic [31:0] r_cnt_byte, n_cnt_byte;
    logic [31:0] r_cnt_msg, n_cnt_msg;
    logic [31:0] r_cnt_rt, n_cnt_rt;
    logic [31:0] r_cnt_err, n_cnt_err;
    logic [7:0]  r_rec_stat, n_rec_stat;
    logic [6:0]  r_rec_d0, n_rec_d0, r_rec_d1, n_rec_d1;
    logic [31:0] r_rec_time, n_rec_time;
    t_event_kind r_kind, n_kind;
    logic        r_out_valid;
    logic        w_accept;

    logic [7:0]  w_st;
    logic [1:0]  w_need;
    logic [1:0]  w_fill;
    logic [6:0]  w_d0, w_d1;
    logic [7:0]  b;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign b          = i_in.data_byte;

    always_comb begin
        n_run_stat  = r_run_stat;
        n_pend_stat = r_pend_stat;
        n_pb0       = r_pb0;
        n_pb1       = r_pb1;
        n_pend_fill = r_pend_fill;
        n_exp_fill  = r_exp_fill;
        n_sysex     = r_sysex;
        n_cnt_byte  = r_cnt_byte;
        n_cnt_msg   = r_cnt_msg;
        n_cnt_rt    = r_cnt_rt;
        n_cnt_err   = r_cnt_err;
        n_rec_stat  = r_rec_stat;
        n_rec_d0    = r_rec_d0;
        n_rec_d1    = r_rec_d1;
        n_rec_time  = r_rec_time;
        n_kind      = EK_ABSORBED;
        w_st        = (r_pend_stat != 8'd0) ? r_pend_stat : r_run_stat;
        w_need      = (r_pend_stat != 8'd0) ? r_exp_fill : needed_data(r_run_stat);
        w_fill      = r_pend_fill;
        w_d0        = 7'd0;
        w_d1        = 7'd0;
        if (r_enable) begin
            n_cnt_byte = r_cnt_byte + 32'd1;
            priority if (b >= RealtimeFirst) begin
                n_cnt_rt   = r_cnt_rt + 32'd1;
                n_rec_time = i_in.time_ms;
                n_rec_stat = b;
                n_rec_d0   = 7'd0;
                n_rec_d1   = 7'd0;
                n_kind     = EK_REALTIME;
            end else if (b == SysexStart) begin
                n_sysex     = 1'b1;
                n_pend_fill = 2'd0;
                n_exp_fill  = 2'd0;
                n_pend_stat = 8'd0;
                n_kind      = EK_SYSEX_ON;
            end else if (b == SysexEnd) begin
                n_sysex = 1'b0;
                n_kind  = EK_SYSEX_OFF;
            end else if (r_sysex) begin
                n_kind = EK_ABSORBED;
            end else if (b[7]) begin
                n_pend_stat = b;
                n_pend_fill = 2'd0;
                n_exp_fill  = needed_data(b);
                if (needed_data(b) != 2'd0) begin
                    n_run_stat = b;
                    n_kind     = EK_ABSORBED;
                end else begin
                    n_cnt_err = r_cnt_err + 32'd1;
                    n_kind    = EK_ERROR;
                end
            end else begin
                if (w_st != 8'd0 && w_need != 2'd0 && w_fill < 2'd2) begin
                    if (w_fill[0]) begin
                        n_pb1 = b[6:0];
                    end else begin
                        n_pb0 = b[6:0];
                    end
                    w_fill      = w_fill + 2'd1;
                    n_pend_fill = w_fill;
                    w_d0        = n_pb0;
                    w_d1        = n_pb1;
                end
                priority if (w_st == 8'd0 || w_need == 2'd0 || w_fill > w_need) begin
                    n_cnt_err = r_cnt_err + 32'd1;
                    n_kind    = EK_ERROR;
                end else if (w_fill >= w_need) begin
                    n_cnt_msg   = r_cnt_msg + 32'd1;
                    n_rec_time  = i_in.time_ms;
                    n_rec_stat  = w_st;
                    n_rec_d0    = w_d0;
                    n_rec_d1    = (w_need > 2'd1) ? w_d1 : 7'd0;
                    n_pend_fill = 2'd0;
                    n_pend_stat = r_run_stat;
                    n_exp_fill  = needed_data(r_run_stat);
                    n_kind      = EK_MESSAGE;
                end else begin
                    n_kind = EK_ABSORBED;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b1;
            r_run_stat  <= 8'd0;
            r_pend_stat <= 8'd0;
            r_pb0       <= 7'd0;
            r_pb1       <= 7'd0;
            r_pend_fill <= 2'd0;
            r_exp_fill  <= 2'd0;
            r_sysex     <= 1'b0;
            r_cnt_byte  <= 32'd0;
            r_cnt_msg   <= 32'd0;
            r_cnt_rt    <= 32'd0;
            r_cnt_err   <= 32'd0;
            r_rec_stat  <= 8'd0;
            r_rec_d0    <= 7'd0;
            r_rec_d1    <= 7'd0;
            r_rec_time  <= 32'd0;
            r_kind      <= EK_ABSORBED;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_enable <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_run_stat  <= n_run_stat;
                r_pend_stat <= n_pend_stat;
                r_pb0       <= n_pb0;
                r_pb1       <= n_pb1;
                r_pend_fill <= n_pend_fill;
                r_exp_fill  <= n_exp_fill;
                r_sysex     <= n_sysex;
                r_cnt_byte  <= n_cnt_byte;
                r_cnt_msg   <= n_cnt_msg;
                r_cnt_rt    <= n_cnt_rt;
                r_cnt_err   <= n_cnt_err;
                r_rec_stat  <= n_rec_stat;
                r_rec_d0    <= n_rec_d0;
                r_rec_d1    <= n_rec_d1;
                r_rec_time  <= n_rec_time;
                r_kind      <= n_kind;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The state registers change only when a new result loads, so they serve as the result.
    always_comb begin
        o_out.valid                  = r_out_valid;
        o_out.event_kind             = r_kind;
        o_out.evt_status             = r_rec_stat;
        o_out.evt_data1              = r_rec_d0;
        o_out.evt_data2              = r_rec_d1;
        o_out.last_event_time        = r_rec_time;
        o_out.byte_total             = r_cnt_byte;
        o_out.message_total          = r_cnt_msg;
        o_out.realtime_total         = r_cnt_rt;
        o_out.error_total            = r_cnt_err;
        o_out.current_running_status = r_run_stat;
        o_out.evt_type               = 8'd0;
        o_out.evt_channel            = 5'd0;
        if (r_rec_stat >= RealtimeFirst) begin
            o_out.evt_type = r_rec_stat;
        end else if (r_rec_stat != 8'd0) begin
            o_out.evt_type    = r_rec_stat & ~ChannelMask;
            o_out.evt_channel = {1'b0, r_rec_stat[3:0]} + 5'd1;
        end
    end

    `MBSP_ASSERT(a_msg_count, i_clk, i_rst_n, w_accept |=> ((r_cnt_msg != $past(r_cnt_msg)) == (r_kind == EK_MESSAGE)), "message count out of step with event kind")
    `MBSP_ASSERT(a_err_count, i_clk, i_rst_n, w_accept |=> ((r_cnt_err != $past(r_cnt_err)) == (r_kind == EK_ERROR)), "error count out of step with event kind")
    `MBSP_ASSERT(a_disabled, i_clk, i_rst_n, (w_accept && !r_enable) |=> (r_cnt_byte == $past(r_cnt_byte) && r_kind == EK_ABSORBED), "disabled parser changed state")
    `MBSP_ASSERT_ALWAYS(a_fill_range, i_clk, !i_rst_n || r_pend_fill != 2'd3, "pending fill out of range")

endmodule
